FILE: sv/boot_region_allocator_defines.svh
// Assertion macros shared by the boot region allocator RTL.
`ifndef BOOT_REGION_ALLOCATOR_DEFINES_SVH
`define BOOT_REGION_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BRA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bra_pkg.sv
// Types, constants and request codes of the boot region allocator.
package bra_pkg;

   localparam int SLOTS    = 32;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int DATA_W   = 64;
   localparam int KIND_W   = 3;
   localparam int ALIGN_W  = 6;
   localparam int RIDX_W   = 5;
   localparam int STATUS_W = 2;
   localparam int FCOUNT_W = 6;
   localparam int CMP_W    = 10;
   localparam int CSR_AW   = 4;
   localparam int CSR_SEL  = 3;

   typedef logic [DATA_W-1:0]   addr_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cnt_type SLOTS_CNT = CNT_W'(SLOTS);

   localparam kind_type KIND_CLEAR   = 3'd0;
   localparam kind_type KIND_MAP     = 3'd1;
   localparam kind_type KIND_FINISH  = 3'd2;
   localparam kind_type KIND_RESERVE = 3'd3;
   localparam kind_type KIND_ALLOC   = 3'd4;
   localparam kind_type KIND_QUERY   = 3'd5;
   localparam kind_type KIND_READ    = 3'd6;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_NOFIT  = 2'd2;
   localparam status_type ST_BADIDX = 2'd3;

   localparam logic REG_KSTART = 1'b0;
   localparam logic REG_KEND   = 1'b1;

   typedef struct packed {
      addr_type a;
      addr_type b;
      logic     sub;
   } alu_req_type;

   typedef struct packed {
      addr_type sum;
      logic     carry;
   } alu_rsp_type;

   typedef struct packed {
      addr_type kernel_start;
      addr_type kernel_end;
   } kcfg_type;

endpackage

FILE: sv/bra_if.sv
// Request and response channel interfaces of the boot region allocator.
interface bra_req_if;
   import bra_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [DATA_W-1:0]   range_base;
   logic [DATA_W-1:0]   range_size;
   logic [ALIGN_W-1:0]  align_log2;
   logic                is_available;
   logic [RIDX_W-1:0]   region_index;

   modport source (output valid, kind, range_base, range_size, align_log2, is_available,
                   region_index, input ready);
   modport sink (input valid, kind, range_base, range_size, align_log2, is_available,
                 region_index, output ready);
endinterface

interface bra_rsp_if;
   import bra_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   address;
   logic [DATA_W-1:0]   length;
   logic                hit;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   free_total;
   logic [DATA_W-1:0]   reserved_total;
   logic [FCOUNT_W-1:0] free_count;

   modport source (output valid, address, length, hit, status, free_total, reserved_total,
                   free_count, input ready);
   modport sink (input valid, address, length, hit, status, free_total, reserved_total,
                 free_count, output ready);
endinterface

FILE: sv/bra_alu.sv
// Shared 64-bit adder/subtractor with carry or borrow out.
module bra_alu (
   input  bra_pkg::alu_req_type req,
   output bra_pkg::alu_rsp_type rsp
);
   import bra_pkg::*;

   logic [DATA_W:0] wide;

   always_comb begin
      if (req.sub) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.sum   = wide[DATA_W-1:0];
      rsp.carry = wide[DATA_W];
   end
endmodule

FILE: sv/bra_csr.sv
// APB register file holding the kernel image range.
module bra_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bra_pkg::CSR_AW-1:0] paddr,
   input  logic [bra_pkg::DATA_W-1:0] pwdata,
   output logic [bra_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output bra_pkg::kcfg_type          cfg
);
   import bra_pkg::*;

   addr_type kstart_ff, kstart_in;
   addr_type kend_ff, kend_in;
   logic     wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      kstart_in = kstart_ff;
      kend_in   = kend_ff;
      if (wr_en) begin
         unique case (paddr[CSR_SEL])
            REG_KSTART: kstart_in = pwdata;
            REG_KEND:   kend_in   = pwdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kstart_ff <= '0;
         kend_ff   <= '0;
      end else begin
         kstart_ff <= kstart_in;
         kend_ff   <= kend_in;
      end
   end

   assign prdata           = (paddr[CSR_SEL] == REG_KEND) ? kend_ff : kstart_ff;
   assign cfg.kernel_start = kstart_ff;
   assign cfg.kernel_end   = kend_ff;
endmodule

FILE: sv/boot_region_allocator.sv
// Boot region allocator: free/reserved region tables and sequencer.
//
// Requests arrive on req_ch (valid/ready) and each gives exactly one response
// on rsp_ch. A request is taken only while the sequencer is idle; ready then
// stays low until its response has been loaded into the output register.
// Every 64-bit add or subtract goes through one shared adder, and each table is
// read at one entry per cycle, so the time a request takes follows the walks:
//   clear, read region and mapping a free range walk no table, query scans
//   the reservations, reserve makes one sorted-merge pass over them, finish
//   init reserves the kernel range and adds an insertion sort of the free entries,
//   alloc tries free regions in turn, scanning the reservations and stepping
//   the candidate past each clash, then carves the free entry and reserves.
// The kernel range is written over the APB port (8 bytes per register).
// Reset empties both tables, zeroes the totals and the kernel range; no
// clearing pass is needed. If the receiver stalls, the response waits in the
// output register and the sequencer holds its finished result until the slot
// frees; the next request may be taken as soon as the response is in the
// output register.
`include "boot_region_allocator_defines.svh"

module boot_region_allocator (
   input  logic                       clock,
   input  logic                       reset,
   bra_req_if.sink                    req_ch,
   bra_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bra_pkg::CSR_AW-1:0] paddr,
   input  logic [bra_pkg::DATA_W-1:0] pwdata,
   output logic [bra_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import bra_pkg::*;

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_MAP        = 5'd1;
   localparam logic [4:0] S_MAP_ADD    = 5'd2;
   localparam logic [4:0] S_KERN       = 5'd3;
   localparam logic [4:0] S_RES_CHK    = 5'd4;
   localparam logic [4:0] S_RES_ADD    = 5'd5;
   localparam logic [4:0] S_MERGE      = 5'd6;
   localparam logic [4:0] S_SORT_LOAD  = 5'd7;
   localparam logic [4:0] S_SORT_STEP  = 5'd8;
   localparam logic [4:0] S_QUERY_INIT = 5'd9;
   localparam logic [4:0] S_QUERY      = 5'd10;
   localparam logic [4:0] S_READ       = 5'd11;
   localparam logic [4:0] S_AL_REGION  = 5'd12;
   localparam logic [4:0] S_AL_FIT     = 5'd13;
   localparam logic [4:0] S_AL_CEND    = 5'd14;
   localparam logic [4:0] S_AL_SCAN    = 5'd15;
   localparam logic [4:0] S_CV_SCAN    = 5'd16;
   localparam logic [4:0] S_CV_CUT     = 5'd17;
   localparam logic [4:0] S_CV_TAIL    = 5'd18;
   localparam logic [4:0] S_CV_MOVE    = 5'd19;
   localparam logic [4:0] S_CV_SUB     = 5'd20;
   localparam logic [4:0] S_DONE       = 5'd21;

   kcfg_type    cfg;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   // tables hold base and exclusive end
   addr_type free_base_ff [SLOTS];
   addr_type free_end_ff  [SLOTS];
   addr_type resv_base_ff [SLOTS];
   addr_type resv_end_ff  [SLOTS];

   logic [4:0]          state_ff, state_in;
   kind_type            kind_ff, kind_in;
   addr_type            base_ff, base_in;
   addr_type            size_ff, size_in;
   addr_type            end_ff, end_in;
   logic [ALIGN_W-1:0]  lg_ff, lg_in;
   logic [RIDX_W-1:0]   idx_ff, idx_in;
   logic                top_ff, top_in;
   addr_type            cand_ff, cand_in;
   addr_type            cend_ff, cend_in;
   addr_type            rs_ff, rs_in;
   addr_type            re_ff, re_in;
   cnt_type             i_ff, i_in;
   cnt_type             j_ff, j_in;
   cnt_type             w_ff, w_in;
   logic                newdone_ff, newdone_in;
   logic                accv_ff, accv_in;
   addr_type            acc_base_ff, acc_base_in;
   addr_type            acc_end_ff, acc_end_in;
   addr_type            key_base_ff, key_base_in;
   addr_type            key_end_ff, key_end_in;
   addr_type            addr_ff, addr_in;
   addr_type            len_ff, len_in;
   logic                hit_ff, hit_in;
   status_type          st_ff, st_in;
   cnt_type             fcnt_ff, fcnt_in;
   cnt_type             rcnt_ff, rcnt_in;
   addr_type            fbytes_ff, fbytes_in;
   addr_type            rbytes_ff, rbytes_in;
   logic                rsp_valid_ff, rsp_valid_in;
   addr_type            rsp_address_ff, rsp_address_in;
   addr_type            rsp_length_ff, rsp_length_in;
   logic                rsp_hit_ff, rsp_hit_in;
   status_type          rsp_status_ff, rsp_status_in;
   addr_type            rsp_free_ff, rsp_free_in;
   addr_type            rsp_resv_ff, rsp_resv_in;
   logic [FCOUNT_W-1:0] rsp_count_ff, rsp_count_in;

   idx_type  free_ra, resv_ra;
   addr_type fr_base, fr_end, rr_base, rr_end;
   logic     free_we, resv_we;
   idx_type  free_wa, resv_wa;
   addr_type free_wbase, free_wend, resv_wbase, resv_wend;
   addr_type mask;
   cnt_type  jm1;
   logic     req_acc;
   logic     take_new;
   addr_type elem_base, elem_end;
   logic [4:0] after_res;

   bra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bra_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_acc = req_ch.valid & req_ch.ready;
   assign mask    = ~({DATA_W{1'b1}} << lg_ff);
   assign jm1     = j_ff - 1'b1;
   assign resv_ra = j_ff[IDX_W-1:0];
   assign fr_base = free_base_ff[free_ra];
   assign fr_end  = free_end_ff[free_ra];
   assign rr_base = resv_base_ff[resv_ra];
   assign rr_end  = resv_end_ff[resv_ra];
   // finish init goes on to sort the free table once its reservation is done
   assign after_res = (kind_ff == KIND_FINISH) ? S_SORT_LOAD : S_DONE;

   always_comb begin
      unique case (state_ff)
         S_SORT_STEP: free_ra = jm1[IDX_W-1:0];
         S_READ:      free_ra = IDX_W'(idx_ff);
         S_CV_MOVE:   free_ra = fcnt_ff[IDX_W-1:0];
         default:     free_ra = i_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      unique case (state_ff)
         S_MAP, S_RES_CHK, S_QUERY_INIT: begin
            alu_req.a = base_ff;
            alu_req.b = size_ff;
         end
         S_MAP_ADD: begin
            alu_req.a = fbytes_ff;
            alu_req.b = size_ff;
         end
         S_RES_ADD: begin
            alu_req.a = rbytes_ff;
            alu_req.b = size_ff;
         end
         S_CV_SUB: begin
            alu_req.a   = fbytes_ff;
            alu_req.b   = size_ff;
            alu_req.sub = 1'b1;
         end
         S_KERN: begin
            alu_req.a   = cfg.kernel_end;
            alu_req.b   = cfg.kernel_start;
            alu_req.sub = 1'b1;
         end
         S_READ: begin
            alu_req.a   = fr_end;
            alu_req.b   = fr_base;
            alu_req.sub = 1'b1;
         end
         S_AL_REGION: begin
            alu_req.a = fr_base;
            alu_req.b = mask;
         end
         S_AL_FIT: begin
            alu_req.a   = re_ff;
            alu_req.b   = size_ff;
            alu_req.sub = 1'b1;
         end
         S_AL_CEND: begin
            alu_req.a = cand_ff;
            alu_req.b = size_ff;
         end
         S_AL_SCAN: begin
            alu_req.a = rr_end;
            alu_req.b = mask;
         end
         default: begin
            alu_req.a = '0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      base_in        = base_ff;
      size_in        = size_ff;
      end_in         = end_ff;
      lg_in          = lg_ff;
      idx_in         = idx_ff;
      top_in         = top_ff;
      cand_in        = cand_ff;
      cend_in        = cend_ff;
      rs_in          = rs_ff;
      re_in          = re_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      w_in           = w_ff;
      newdone_in     = newdone_ff;
      accv_in        = accv_ff;
      acc_base_in    = acc_base_ff;
      acc_end_in     = acc_end_ff;
      key_base_in    = key_base_ff;
      key_end_in     = key_end_ff;
      addr_in        = addr_ff;
      len_in         = len_ff;
      hit_in         = hit_ff;
      st_in          = st_ff;
      fcnt_in        = fcnt_ff;
      rcnt_in        = rcnt_ff;
      fbytes_in      = fbytes_ff;
      rbytes_in      = rbytes_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;
      rsp_address_in = rsp_address_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_resv_in    = rsp_resv_ff;
      rsp_count_in   = rsp_count_ff;
      free_we        = 1'b0;
      free_wa        = i_ff[IDX_W-1:0];
      free_wbase     = fr_base;
      free_wend      = fr_end;
      resv_we        = 1'b0;
      resv_wa        = w_ff[IDX_W-1:0];
      resv_wbase     = acc_base_ff;
      resv_wend      = acc_end_ff;
      take_new       = 1'b0;
      elem_base      = rr_base;
      elem_end       = rr_end;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               kind_in = req_ch.kind;
               base_in = req_ch.range_base;
               size_in = req_ch.range_size;
               lg_in   = req_ch.align_log2;
               idx_in  = req_ch.region_index;
               addr_in = '0;
               len_in  = '0;
               hit_in  = 1'b0;
               st_in   = ST_OK;
               i_in    = '0;
               unique case (req_ch.kind)
                  KIND_CLEAR: begin
                     fcnt_in   = '0;
                     rcnt_in   = '0;
                     fbytes_in = '0;
                     rbytes_in = '0;
                     state_in  = S_DONE;
                  end
                  KIND_MAP:     state_in = req_ch.is_available ? S_MAP : S_RES_CHK;
                  KIND_FINISH:  state_in = S_KERN;
                  KIND_RESERVE: state_in = S_RES_CHK;
                  KIND_ALLOC: begin
                     if (req_ch.range_size == '0) begin
                        st_in    = ST_NOFIT;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_AL_REGION;
                     end
                  end
                  KIND_QUERY:   state_in = S_QUERY_INIT;
                  KIND_READ:    state_in = S_READ;
                  default:      state_in = S_DONE;
               endcase
            end
         end

         S_MAP: begin
            if (alu_rsp.carry) begin
               st_in    = ST_NOFIT;
               state_in = S_DONE;
            end else if (fcnt_ff >= SLOTS_CNT) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               free_we    = 1'b1;
               free_wa    = fcnt_ff[IDX_W-1:0];
               free_wbase = base_ff;
               free_wend  = alu_rsp.sum;
               fcnt_in    = fcnt_ff + 1'b1;
               state_in   = S_MAP_ADD;
            end
         end

         S_MAP_ADD: begin
            fbytes_in = alu_rsp.sum;
            state_in  = S_DONE;
         end

         S_KERN: begin
            base_in  = cfg.kernel_start;
            size_in  = alu_rsp.sum;
            state_in = S_RES_CHK;
         end

         S_RES_CHK: begin
            i_in = CNT_W'(1);
            if (size_ff == '0) begin
               state_in = after_res;
            end else if (alu_rsp.carry) begin
               st_in    = ST_NOFIT;
               state_in = after_res;
            end else if (rcnt_ff >= SLOTS_CNT) begin
               st_in    = ST_FULL;
               state_in = after_res;
            end else begin
               end_in     = alu_rsp.sum;
               j_in       = '0;
               w_in       = '0;
               newdone_in = 1'b0;
               accv_in    = 1'b0;
               state_in   = S_RES_ADD;
            end
         end

         S_RES_ADD: begin
            rbytes_in = alu_rsp.sum;
            state_in  = S_MERGE;
         end

         // one pass: sorted insert of the new range merged with the old entries,
         // written back in place behind the read pointer
         S_MERGE: begin
            if ((j_ff == rcnt_ff) && newdone_ff) begin
               resv_we  = 1'b1;
               rcnt_in  = w_ff + 1'b1;
               state_in = after_res;
            end else begin
               take_new = ~newdone_ff & ((j_ff == rcnt_ff) || (rr_base > base_ff));
               if (take_new) begin
                  elem_base  = base_ff;
                  elem_end   = end_ff;
                  newdone_in = 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
               if (!accv_ff) begin
                  accv_in     = 1'b1;
                  acc_base_in = elem_base;
                  acc_end_in  = elem_end;
               end else if (elem_base <= acc_end_ff) begin
                  if (elem_end > acc_end_ff) begin
                     acc_end_in = elem_end;
                  end
               end else begin
                  resv_we     = 1'b1;
                  w_in        = w_ff + 1'b1;
                  acc_base_in = elem_base;
                  acc_end_in  = elem_end;
               end
            end
         end

         S_SORT_LOAD: begin
            if (i_ff >= fcnt_ff) begin
               state_in = S_DONE;
            end else begin
               key_base_in = fr_base;
               key_end_in  = fr_end;
               j_in        = i_ff;
               state_in    = S_SORT_STEP;
            end
         end

         S_SORT_STEP: begin
            free_we = 1'b1;
            free_wa = j_ff[IDX_W-1:0];
            if ((j_ff != '0) && (fr_base > key_base_ff)) begin
               j_in = jm1;
            end else begin
               free_wbase = key_base_ff;
               free_wend  = key_end_ff;
               i_in       = i_ff + 1'b1;
               state_in   = S_SORT_LOAD;
            end
         end

         S_QUERY_INIT: begin
            end_in = alu_rsp.sum;
            top_in = alu_rsp.carry;
            j_in   = '0;
            state_in = (size_ff == '0) ? S_DONE : S_QUERY;
         end

         S_QUERY: begin
            if (j_ff == rcnt_ff) begin
               state_in = S_DONE;
            end else if (!top_ff && (rr_base >= end_ff)) begin
               state_in = S_DONE;
            end else if ((base_ff < rr_end) && (top_ff || (end_ff > rr_base))) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end

         S_READ: begin
            if (CMP_W'(idx_ff) < CMP_W'(fcnt_ff)) begin
               addr_in = fr_base;
               len_in  = alu_rsp.sum;
            end else begin
               st_in = ST_BADIDX;
            end
            state_in = S_DONE;
         end

         S_AL_REGION: begin
            if (i_ff >= fcnt_ff) begin
               st_in    = ST_NOFIT;
               state_in = S_DONE;
            end else if (alu_rsp.carry) begin
               i_in = i_ff + 1'b1;
            end else begin
               cand_in  = alu_rsp.sum & ~mask;
               re_in    = fr_end;
               state_in = S_AL_FIT;
            end
         end

         S_AL_FIT: begin
            if (alu_rsp.carry || (cand_ff > alu_rsp.sum)) begin
               i_in     = i_ff + 1'b1;
               state_in = S_AL_REGION;
            end else begin
               j_in     = '0;
               state_in = S_AL_CEND;
            end
         end

         S_AL_CEND: begin
            cend_in  = alu_rsp.sum;
            state_in = S_AL_SCAN;
         end

         S_AL_SCAN: begin
            if ((j_ff == rcnt_ff) || (rr_base >= cend_ff)) begin
               if (rcnt_ff >= SLOTS_CNT) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  base_in  = cand_ff;
                  end_in   = cend_ff;
                  addr_in  = cand_ff;
                  i_in     = '0;
                  state_in = S_CV_SCAN;
               end
            end else if ((cand_ff < rr_end) && (cend_ff > rr_base)) begin
               // step the candidate past this reservation
               if (alu_rsp.carry) begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_AL_REGION;
               end else begin
                  cand_in  = alu_rsp.sum & ~mask;
                  state_in = S_AL_FIT;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end

         S_CV_SCAN: begin
            if (i_ff >= fcnt_ff) begin
               state_in = S_RES_CHK;
            end else if ((base_ff < fr_base) || (end_ff > fr_end)) begin
               i_in = i_ff + 1'b1;
            end else begin
               rs_in    = fr_base;
               re_in    = fr_end;
               state_in = S_CV_CUT;
            end
         end

         S_CV_CUT: begin
            if (base_ff != rs_ff) begin
               free_we    = 1'b1;
               free_wbase = rs_ff;
               free_wend  = base_ff;
               // right-hand part is lost when the table is full
               state_in   = ((re_ff != end_ff) && (fcnt_ff < SLOTS_CNT)) ? S_CV_TAIL : S_CV_SUB;
            end else if (re_ff != end_ff) begin
               free_we    = 1'b1;
               free_wbase = end_ff;
               free_wend  = re_ff;
               state_in   = S_CV_SUB;
            end else begin
               fcnt_in  = fcnt_ff - 1'b1;
               state_in = S_CV_MOVE;
            end
         end

         S_CV_TAIL: begin
            free_we    = 1'b1;
            free_wa    = fcnt_ff[IDX_W-1:0];
            free_wbase = end_ff;
            free_wend  = re_ff;
            fcnt_in    = fcnt_ff + 1'b1;
            state_in   = S_CV_SUB;
         end

         S_CV_MOVE: begin
            free_we  = 1'b1;
            state_in = S_CV_SUB;
         end

         S_CV_SUB: begin
            fbytes_in = alu_rsp.sum;
            state_in  = S_RES_CHK;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = addr_ff;
               rsp_length_in  = len_ff;
               rsp_hit_in     = hit_ff;
               rsp_status_in  = st_ff;
               rsp_free_in    = fbytes_ff;
               rsp_resv_in    = rbytes_ff;
               rsp_count_in   = FCOUNT_W'(fcnt_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fcnt_ff      <= '0;
         rcnt_ff      <= '0;
         fbytes_ff    <= '0;
         rbytes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcnt_ff      <= fcnt_in;
         rcnt_ff      <= rcnt_in;
         fbytes_ff    <= fbytes_in;
         rbytes_ff    <= rbytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      base_ff        <= base_in;
      size_ff        <= size_in;
      end_ff         <= end_in;
      lg_ff          <= lg_in;
      idx_ff         <= idx_in;
      top_ff         <= top_in;
      cand_ff        <= cand_in;
      cend_ff        <= cend_in;
      rs_ff          <= rs_in;
      re_ff          <= re_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      w_ff           <= w_in;
      newdone_ff     <= newdone_in;
      accv_ff        <= accv_in;
      acc_base_ff    <= acc_base_in;
      acc_end_ff     <= acc_end_in;
      key_base_ff    <= key_base_in;
      key_end_ff     <= key_end_in;
      addr_ff        <= addr_in;
      len_ff         <= len_in;
      hit_ff         <= hit_in;
      st_ff          <= st_in;
      rsp_address_ff <= rsp_address_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_resv_ff    <= rsp_resv_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_base_ff[free_wa] <= free_wbase;
         free_end_ff[free_wa]  <= free_wend;
      end
      if (resv_we) begin
         resv_base_ff[resv_wa] <= resv_wbase;
         resv_end_ff[resv_wa]  <= resv_wend;
      end
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.address        = rsp_address_ff;
   assign rsp_ch.length         = rsp_length_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.free_total     = rsp_free_ff;
   assign rsp_ch.reserved_total = rsp_resv_ff;
   assign rsp_ch.free_count     = rsp_count_ff;

   `BRA_ASSERT_HOLDS(a_free_cnt_max, clock, reset, fcnt_ff <= SLOTS_CNT, "free table overfilled")
   `BRA_ASSERT_HOLDS(a_resv_cnt_max, clock, reset, rcnt_ff <= SLOTS_CNT, "reserved table overfilled")
   `BRA_ASSERT_HOLDS(a_merge_behind, clock, reset, (state_ff != S_MERGE) || (w_ff <= j_ff), "merge write overtook read")
   `BRA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
endmodule
